// ===== rtl/core/dbam_pkg.sv =====
// ----------------------------------------------------------------------------
// dbam_pkg
// Shared widths, command and status codes, zone tables and the result bundle
// for the disk block allocation map.
// ----------------------------------------------------------------------------
package dbam_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned TRACK_W  = 6;
  localparam int unsigned SECTOR_W = 5;
  localparam int unsigned MAP_W    = 24;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned TOTAL_W  = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ENTRY_W  = MAP_W + CNT_W;

  localparam logic [OP_W-1:0] OP_QUERY  = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
  localparam logic [OP_W-1:0] OP_FORMAT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_USED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  localparam logic [TRACK_W-1:0] RESET_TRACKS = 6'd35;

  localparam logic [TRACK_W-1:0] ZONE0_LAST = 6'd17;
  localparam logic [TRACK_W-1:0] ZONE1_LAST = 6'd24;
  localparam logic [TRACK_W-1:0] ZONE2_LAST = 6'd30;

  localparam logic [CNT_W-1:0] ZONE0_SIZE = 5'd21;
  localparam logic [CNT_W-1:0] ZONE1_SIZE = 5'd19;
  localparam logic [CNT_W-1:0] ZONE2_SIZE = 5'd18;
  localparam logic [CNT_W-1:0] ZONE3_SIZE = 5'd17;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                block_is_free;
    logic [TRACK_W-1:0]  found_track;
    logic [SECTOR_W-1:0] found_sector;
    logic [CNT_W-1:0]    track_free_count;
    logic [TOTAL_W-1:0]  disk_free_count;
  } result_t;

  function automatic logic [CNT_W-1:0] zone_size(input logic [TRACK_W-1:0] t);
    logic [CNT_W-1:0] z;
    if (t <= ZONE0_LAST) begin
      z = ZONE0_SIZE;
    end else if (t <= ZONE1_LAST) begin
      z = ZONE1_SIZE;
    end else if (t <= ZONE2_LAST) begin
      z = ZONE2_SIZE;
    end else begin
      z = ZONE3_SIZE;
    end
    return z;
  endfunction

  function automatic logic [MAP_W-1:0] zone_mask(input logic [TRACK_W-1:0] t);
    logic [MAP_W-1:0] m;
    m = (MAP_W'(1) << zone_size(t)) - MAP_W'(1);
    return m;
  endfunction

  // lowest set bit of a bitmap word
  function automatic logic [SECTOR_W-1:0] lowest_set(input logic [MAP_W-1:0] map);
    logic [SECTOR_W-1:0] s;
    s = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (map[i]) begin
        s = SECTOR_W'(i);
      end
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/disk_block_allocation_map_top.sv =====
// ----------------------------------------------------------------------------
// disk_block_allocation_map_top
// Block allocation map with per-track free bitmaps and counts.
// ----------------------------------------------------------------------------
// One request at a time. Every request ends with a sweep that reads one map
// entry per cycle over the active tracks to rebuild the disk free total.
// Allocate next free first reads candidate tracks on the same map port, and
// format first writes every map entry. After reset a clearing pass lays down
// the 35-track format before the first request is taken. A finished result
// waits in the output register, so the next request may be taken while it is
// still stalled.
module disk_block_allocation_map_top #(
  parameter int unsigned MAX_TRACKS      = 40,
  parameter int unsigned DIRECTORY_TRACK = 18
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               track_count_we_i,
  input  logic [dbam_pkg::TRACK_W-1:0]       track_count_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [dbam_pkg::OP_W-1:0]          opcode_i,
  input  logic [dbam_pkg::TRACK_W-1:0]       track_i,
  input  logic [dbam_pkg::SECTOR_W-1:0]      sector_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [dbam_pkg::STATUS_W-1:0]      status_o,
  output logic                               block_is_free_o,
  output logic [dbam_pkg::TRACK_W-1:0]       found_track_o,
  output logic [dbam_pkg::SECTOR_W-1:0]      found_sector_o,
  output logic [dbam_pkg::CNT_W-1:0]         track_free_count_o,
  output logic [dbam_pkg::TOTAL_W-1:0]       disk_free_count_o
);

  localparam logic [dbam_pkg::TRACK_W-1:0] MAX_T = dbam_pkg::TRACK_W'(MAX_TRACKS);

  logic [dbam_pkg::TRACK_W-1:0] track_count_q, track_count_d;
  logic [dbam_pkg::TRACK_W-1:0] active_tracks;
  logic                         out_valid_q, out_valid_d;
  dbam_pkg::result_t            res_q, res_d, core_res;
  logic                         core_valid, core_ready;

  assign track_count_d = track_count_we_i ? track_count_i : track_count_q;
  assign active_tracks = (track_count_q > MAX_T) ? MAX_T : track_count_q;

  dbam_core #(
    .MAX_TRACKS      (MAX_TRACKS),
    .DIRECTORY_TRACK (DIRECTORY_TRACK)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .track_i         (track_i),
    .sector_i        (sector_i),
    .active_tracks_i (active_tracks),
    .res_ready_i     (core_ready),
    .res_valid_o     (core_valid),
    .res_o           (core_res)
  );

  // output register
  assign core_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (core_valid && core_ready) begin
      out_valid_d = 1'b1;
      res_d       = core_res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_count_q <= dbam_pkg::RESET_TRACKS;
      out_valid_q   <= 1'b0;
    end else begin
      track_count_q <= track_count_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = res_q.status;
  assign block_is_free_o    = res_q.block_is_free;
  assign found_track_o      = res_q.found_track;
  assign found_sector_o     = res_q.found_sector;
  assign track_free_count_o = res_q.track_free_count;
  assign disk_free_count_o  = res_q.disk_free_count;

endmodule

// ===== rtl/core/dbam_ram.sv =====
// ----------------------------------------------------------------------------
// dbam_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dbam_ram #(
  parameter int unsigned WIDTH = 29,
  parameter int unsigned DEPTH = 41
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dbam_core.sv =====
// ----------------------------------------------------------------------------
// dbam_core
// Sequencer and shared datapath: one map entry read or written per cycle for
// block operations, next-free search, format sweep and free-total sweep.
// ----------------------------------------------------------------------------
module dbam_core #(
  parameter int unsigned MAX_TRACKS      = 40,
  parameter int unsigned DIRECTORY_TRACK = 18
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dbam_pkg::OP_W-1:0]        opcode_i,
  input  logic [dbam_pkg::TRACK_W-1:0]     track_i,
  input  logic [dbam_pkg::SECTOR_W-1:0]    sector_i,
  input  logic [dbam_pkg::TRACK_W-1:0]     active_tracks_i,
  input  logic                             res_ready_i,
  output logic                             res_valid_o,
  output dbam_pkg::result_t                res_o
);

  localparam int unsigned DEPTH = MAX_TRACKS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned TW    = dbam_pkg::TRACK_W;
  localparam int unsigned CW    = dbam_pkg::CNT_W;
  localparam int unsigned MW    = dbam_pkg::MAP_W;
  localparam int unsigned EW    = dbam_pkg::ENTRY_W;
  localparam logic [TW-1:0] MAX_T = TW'(MAX_TRACKS);
  localparam logic [TW-1:0] DIR_T = TW'(DIRECTORY_TRACK);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_OP     = 7'b0000100,
    S_SEARCH = 7'b0001000,
    S_FORMAT = 7'b0010000,
    S_SUM    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  function automatic logic [EW-1:0] fmt_entry(input logic [TW-1:0] t,
                                              input logic [TW-1:0] n);
    logic [CW-1:0] z;
    logic [MW-1:0] m;
    logic [EW-1:0] e;
    z = dbam_pkg::zone_size(t);
    m = dbam_pkg::zone_mask(t);
    if (t == '0 || t > n) begin
      e = '0;
    end else if (t == DIR_T) begin
      e = {m & ~MW'(3), z - CW'(2)};
    end else begin
      e = {m, z};
    end
    return e;
  endfunction

  state_e                          state_q, state_d;
  logic [dbam_pkg::OP_W-1:0]       op_q, op_d;
  logic [TW-1:0]                   trk_q, trk_d;
  logic [dbam_pkg::SECTOR_W-1:0]   sec_q, sec_d;
  logic [TW-1:0]                   n_q, n_d;
  logic [TW-1:0]                   ctr_q, ctr_d;
  logic                            up_q, up_d;
  logic                            pend_q, pend_d;
  logic [TW-1:0]                   pend_trk_q, pend_trk_d;
  logic [dbam_pkg::STATUS_W-1:0]   status_q, status_d;
  logic                            free_q, free_d;
  logic [TW-1:0]                   ft_q, ft_d;
  logic [dbam_pkg::SECTOR_W-1:0]   fs_q, fs_d;
  logic [CW-1:0]                   tcnt_q, tcnt_d;
  logic [dbam_pkg::TOTAL_W-1:0]    acc_q, acc_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [MW-1:0] rd_map, rd_shift, take_map;
  logic [CW-1:0] rd_cnt;
  logic [EW-1:0] fmt_trk;

  logic                          accept, in_range, blk_ok, cur_free;
  logic [MW-1:0]                 sec_bit;
  logic [TW-1:0]                 cand_dn, cand;
  logic [TW:0]                   up_sum;
  logic                          down_ok, up_ok, cand_ok, gen_done, pend_hit, sum_rd_ok;
  logic [dbam_pkg::SECTOR_W-1:0] fs_hit;

  dbam_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_map = ram_rdata[EW-1:CW];
  assign rd_cnt = ram_rdata[CW-1:0];

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // addressed block
  assign in_range = (trk_q != '0) && (trk_q <= n_q);
  assign blk_ok   = in_range && (sec_q < dbam_pkg::zone_size(trk_q));
  assign rd_shift = rd_map >> sec_q;
  assign cur_free = blk_ok && rd_shift[0];
  assign sec_bit  = MW'(1) << sec_q;
  assign fmt_trk  = fmt_entry(trk_q, n_q);

  // next-free candidate order: dir-k, then dir+k
  assign cand_dn  = DIR_T - ctr_q;
  assign down_ok  = (ctr_q < DIR_T) && (cand_dn <= n_q);
  assign up_sum   = {1'b0, DIR_T} + {1'b0, ctr_q};
  assign up_ok    = up_sum <= {1'b0, n_q};
  assign cand     = up_q ? up_sum[TW-1:0] : cand_dn;
  assign cand_ok  = up_q ? up_ok : down_ok;
  assign gen_done = ctr_q > n_q;
  assign pend_hit = pend_q && (rd_map != '0);
  assign fs_hit   = dbam_pkg::lowest_set(rd_map);
  assign take_map = rd_map & ~(MW'(1) << fs_hit);

  assign sum_rd_ok = ctr_q <= n_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_INIT, S_FORMAT: begin
        ram_we    = 1'b1;
        ram_waddr = ctr_q[AW-1:0];
        ram_wdata = fmt_entry(ctr_q, n_q);
      end
      S_IDLE: begin
        ram_re    = accept;
        ram_raddr = (track_i <= MAX_T) ? track_i[AW-1:0] : '0;
      end
      S_OP: begin
        ram_waddr = trk_q[AW-1:0];
        if (op_q == dbam_pkg::OP_ALLOC && cur_free) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_map & ~sec_bit, rd_cnt - CW'(1)};
        end else if (op_q == dbam_pkg::OP_FREE && blk_ok && !cur_free) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_map | sec_bit, rd_cnt + CW'(1)};
        end
      end
      S_SEARCH: begin
        if (pend_hit) begin
          ram_we    = 1'b1;
          ram_waddr = pend_trk_q[AW-1:0];
          ram_wdata = {take_map, rd_cnt - CW'(1)};
        end else begin
          ram_re    = cand_ok && !gen_done;
          ram_raddr = cand[AW-1:0];
        end
      end
      S_SUM: begin
        ram_re    = sum_rd_ok;
        ram_raddr = ctr_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    trk_d      = trk_q;
    sec_d      = sec_q;
    n_d        = n_q;
    ctr_d      = ctr_q;
    up_d       = up_q;
    pend_d     = pend_q;
    pend_trk_d = pend_trk_q;
    status_d   = status_q;
    free_d     = free_q;
    ft_d       = ft_q;
    fs_d       = fs_q;
    tcnt_d     = tcnt_q;
    acc_d      = acc_q;
    case (state_q)
      S_INIT: begin
        ctr_d = ctr_q + TW'(1);
        if (ctr_q == MAX_T) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d    = opcode_i;
          trk_d   = track_i;
          sec_d   = sector_i;
          n_d     = active_tracks_i;
          state_d = S_OP;
        end
      end
      S_OP: begin
        free_d = cur_free;
        ft_d   = '0;
        fs_d   = '0;
        ctr_d  = TW'(1);
        pend_d = 1'b0;
        acc_d  = '0;
        up_d   = 1'b0;
        state_d = S_SUM;
        case (op_q)
          dbam_pkg::OP_ALLOC: begin
            status_d = !blk_ok   ? dbam_pkg::ST_INVALID :
                       !cur_free ? dbam_pkg::ST_USED : dbam_pkg::ST_OK;
            tcnt_d   = !in_range ? '0 : (cur_free ? rd_cnt - CW'(1) : rd_cnt);
          end
          dbam_pkg::OP_FREE: begin
            status_d = blk_ok ? dbam_pkg::ST_OK : dbam_pkg::ST_INVALID;
            tcnt_d   = !in_range ? '0 :
                       ((blk_ok && !cur_free) ? rd_cnt + CW'(1) : rd_cnt);
          end
          dbam_pkg::OP_NEXT: begin
            status_d = dbam_pkg::ST_OK;
            tcnt_d   = in_range ? rd_cnt : '0;
            state_d  = S_SEARCH;
          end
          dbam_pkg::OP_FORMAT: begin
            status_d = dbam_pkg::ST_OK;
            tcnt_d   = fmt_trk[CW-1:0];
            ctr_d    = '0;
            state_d  = S_FORMAT;
          end
          default: begin
            status_d = blk_ok ? dbam_pkg::ST_OK : dbam_pkg::ST_INVALID;
            tcnt_d   = in_range ? rd_cnt : '0;
          end
        endcase
      end
      S_SEARCH: begin
        if (pend_hit) begin
          ft_d    = pend_trk_q;
          fs_d    = fs_hit;
          tcnt_d  = rd_cnt - CW'(1);
          ctr_d   = TW'(1);
          pend_d  = 1'b0;
          state_d = S_SUM;
        end else if (gen_done && !pend_q) begin
          status_d = dbam_pkg::ST_FULL;
          ctr_d    = TW'(1);
          state_d  = S_SUM;
        end else begin
          pend_d     = cand_ok && !gen_done;
          pend_trk_d = cand;
          if (!gen_done) begin
            up_d = !up_q;
            if (up_q) begin
              ctr_d = ctr_q + TW'(1);
            end
          end
        end
      end
      S_FORMAT: begin
        ctr_d = ctr_q + TW'(1);
        if (ctr_q == MAX_T) begin
          ctr_d   = TW'(1);
          pend_d  = 1'b0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        pend_d     = sum_rd_ok;
        pend_trk_d = ctr_q;
        if (sum_rd_ok) begin
          ctr_d = ctr_q + TW'(1);
        end
        if (pend_q && pend_trk_q != DIR_T) begin
          acc_d = acc_q + dbam_pkg::TOTAL_W'(rd_cnt);
        end
        if (!sum_rd_ok && !pend_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      n_q     <= (dbam_pkg::RESET_TRACKS > MAX_T) ? MAX_T : dbam_pkg::RESET_TRACKS;
      ctr_q   <= '0;
      up_q    <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      ctr_q   <= ctr_d;
      up_q    <= up_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    trk_q      <= trk_d;
    sec_q      <= sec_d;
    pend_trk_q <= pend_trk_d;
    status_q   <= status_d;
    free_q     <= free_d;
    ft_q       <= ft_d;
    fs_q       <= fs_d;
    tcnt_q     <= tcnt_d;
    acc_q      <= acc_d;
  end

  assign res_valid_o            = (state_q == S_DONE);
  assign res_o.status           = status_q;
  assign res_o.block_is_free    = free_q;
  assign res_o.found_track      = ft_q;
  assign res_o.found_sector     = fs_q;
  assign res_o.track_free_count = tcnt_q;
  assign res_o.disk_free_count  = acc_q;

  a_accept_to_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_OP)
    else $error("request not followed by block operation");

  a_found_track_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH && pend_hit) |->
      (pend_trk_q != DIR_T && pend_trk_q != '0 && pend_trk_q <= n_q))
    else $error("next-free search took an illegal track");

  a_found_sector_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH && pend_hit) |-> fs_hit < dbam_pkg::zone_size(pend_trk_q))
    else $error("next-free search took a sector outside the zone");

  a_no_write_in_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM || state_q == S_DONE) |-> !ram_we)
    else $error("map written during free-total sweep");

endmodule

// ===== tb/sv/disk_block_allocation_map_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// disk_block_allocation_map_top_tb
// Self-checking bench for the disk block allocation map. Query, allocate,
// free, allocate-next and format requests go in through the valid/stall
// handshake. The bench keeps its own copy of the free bitmaps and counts,
// works out each result as a request is taken, and compares every returned
// field in order. Both sides idle at random, and the track count register is
// swept between phases.
// ----------------------------------------------------------------------------
module disk_block_allocation_map_top_tb;

  localparam int unsigned MAX_TRK   = 40;
  localparam int unsigned ROOT_TRK  = 18;
  localparam int unsigned SETTLE    = 200;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned STUCK_MAX = 4000;

  localparam logic [dbam_pkg::TRACK_W-1:0] ROOT_T = dbam_pkg::TRACK_W'(ROOT_TRK);

  localparam logic [dbam_pkg::OP_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [dbam_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [dbam_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

  logic                          clk_i            = 1'b0;
  logic                          rst_ni           = 1'b0;
  logic                          track_count_we_i = 1'b0;
  logic [dbam_pkg::TRACK_W-1:0]  track_count_i    = '0;
  logic                          in_valid_i       = 1'b0;
  logic                          in_stall_o;
  logic [dbam_pkg::OP_W-1:0]     opcode_i         = '0;
  logic [dbam_pkg::TRACK_W-1:0]  track_i          = '0;
  logic [dbam_pkg::SECTOR_W-1:0] sector_i         = '0;
  logic                          out_valid_o;
  logic                          out_stall_i      = 1'b0;
  logic [dbam_pkg::STATUS_W-1:0] status_o;
  logic                          block_is_free_o;
  logic [dbam_pkg::TRACK_W-1:0]  found_track_o;
  logic [dbam_pkg::SECTOR_W-1:0] found_sector_o;
  logic [dbam_pkg::CNT_W-1:0]    track_free_count_o;
  logic [dbam_pkg::TOTAL_W-1:0]  disk_free_count_o;

  // own copy of the allocation state
  logic [dbam_pkg::MAP_W-1:0]    free_map [0:MAX_TRK];
  logic [dbam_pkg::CNT_W-1:0]    free_cnt [0:MAX_TRK];
  logic [dbam_pkg::TRACK_W-1:0]  tracks_cfg;
  dbam_pkg::result_t             pending_results [$];

  int n_fail      = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_invalid   = 0;
  int n_used      = 0;
  int n_full      = 0;
  int idle_cycles = 0;
  int hold_left   = 0;
  int gap_left    = 0;
  bit hold_req    = 1'b0;
  bit hold_ack    = 1'b0;
  bit sender_gaps   = 1'b1;
  bit receiver_gaps = 1'b1;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  disk_block_allocation_map_top #(
    .MAX_TRACKS      (MAX_TRK),
    .DIRECTORY_TRACK (ROOT_TRK)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .track_count_we_i   (track_count_we_i),
    .track_count_i      (track_count_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .track_i            (track_i),
    .sector_i           (sector_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .block_is_free_o    (block_is_free_o),
    .found_track_o      (found_track_o),
    .found_sector_o     (found_sector_o),
    .track_free_count_o (track_free_count_o),
    .disk_free_count_o  (disk_free_count_o)
  );

  function automatic int sectors_on_track(int t);
    if (t <= int'(dbam_pkg::ZONE0_LAST)) begin
      return dbam_pkg::ZONE0_SIZE;
    end else if (t <= int'(dbam_pkg::ZONE1_LAST)) begin
      return dbam_pkg::ZONE1_SIZE;
    end else if (t <= int'(dbam_pkg::ZONE2_LAST)) begin
      return dbam_pkg::ZONE2_SIZE;
    end
    return dbam_pkg::ZONE3_SIZE;
  endfunction

  function automatic int live_tracks();
    return (tracks_cfg > MAX_TRK) ? MAX_TRK : int'(tracks_cfg);
  endfunction

  function automatic bit addr_ok(int t, int s, int n);
    return t >= 1 && t <= n && s < sectors_on_track(t);
  endfunction

  function automatic void take_sector(int t, int s);
    free_map[t][s] = 1'b0;
    free_cnt[t]    = free_cnt[t] - 1'b1;
  endfunction

  function automatic void format_map(int n);
    for (int t = 1; t <= MAX_TRK; t++) begin
      if (t <= n) begin
        free_map[t] = (dbam_pkg::MAP_W'(1) << sectors_on_track(t)) - dbam_pkg::MAP_W'(1);
        free_cnt[t] = dbam_pkg::CNT_W'(sectors_on_track(t));
      end else begin
        free_map[t] = '0;
        free_cnt[t] = '0;
      end
    end
    free_map[0] = '0;
    free_cnt[0] = '0;
    // directory sectors 0 and 1
    for (int s = 0; s < 2; s++) begin
      if (addr_ok(ROOT_TRK, s, n) && free_map[ROOT_TRK][s]) begin
        take_sector(ROOT_TRK, s);
      end
    end
  endfunction

  function automatic logic [dbam_pkg::TOTAL_W-1:0] disk_total(int n);
    int sum;
    sum = 0;
    for (int t = 1; t <= n; t++) begin
      if (t != ROOT_TRK) begin
        sum += free_cnt[t];
      end
    end
    return dbam_pkg::TOTAL_W'(sum);
  endfunction

  function automatic bit claim_lowest(int t, int n, output int ft, output int fs);
    if (t < 1 || t > n) begin
      return 1'b0;
    end
    for (int s = 0; s < sectors_on_track(t); s++) begin
      if (free_map[t][s]) begin
        take_sector(t, s);
        ft = t;
        fs = s;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic dbam_pkg::result_t apply_request(logic [dbam_pkg::OP_W-1:0] op,
                                                      logic [dbam_pkg::TRACK_W-1:0] tr,
                                                      logic [dbam_pkg::SECTOR_W-1:0] sec);
    int                n, t, s, ft, fs, cnt;
    bit                ok, was_free, found;
    dbam_pkg::result_t r;
    n        = live_tracks();
    t        = tr;
    s        = sec;
    ok       = addr_ok(t, s, n);
    was_free = ok && free_map[t][s];
    found    = 1'b0;
    ft       = 0;
    fs       = 0;
    r        = '0;
    r.status = dbam_pkg::ST_OK;
    case (op)
      dbam_pkg::OP_ALLOC: begin
        if (!ok) begin
          r.status = dbam_pkg::ST_INVALID;
        end else if (!was_free) begin
          r.status = dbam_pkg::ST_USED;
        end else begin
          take_sector(t, s);
        end
      end
      dbam_pkg::OP_FREE: begin
        if (!ok) begin
          r.status = dbam_pkg::ST_INVALID;
        end else if (!was_free) begin
          free_map[t][s] = 1'b1;
          free_cnt[t]    = free_cnt[t] + 1'b1;
        end
      end
      dbam_pkg::OP_NEXT: begin
        // below the directory track first, then above, moving outwards
        for (int k = 1; k <= n && !found; k++) begin
          found = claim_lowest(int'(ROOT_TRK) - k, n, ft, fs);
          if (!found) begin
            found = claim_lowest(int'(ROOT_TRK) + k, n, ft, fs);
          end
        end
        if (!found) begin
          r.status = dbam_pkg::ST_FULL;
        end
      end
      dbam_pkg::OP_FORMAT: begin
        format_map(n);
      end
      default: begin
        if (!ok) begin
          r.status = dbam_pkg::ST_INVALID;
        end
      end
    endcase
    if (found) begin
      cnt = free_cnt[ft];
    end else if (t >= 1 && t <= n) begin
      cnt = free_cnt[t];
    end else begin
      cnt = 0;
    end
    r.block_is_free    = was_free;
    r.found_track      = dbam_pkg::TRACK_W'(ft);
    r.found_sector     = dbam_pkg::SECTOR_W'(fs);
    r.track_free_count = dbam_pkg::CNT_W'(cnt);
    r.disk_free_count  = disk_total(n);
    return r;
  endfunction

  task automatic send_request(logic [dbam_pkg::OP_W-1:0] op,
                              logic [dbam_pkg::TRACK_W-1:0] tr,
                              logic [dbam_pkg::SECTOR_W-1:0] sec);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    track_i    <= tr;
    sector_i   <= sec;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(apply_request(op, tr, sec));
    n_sent++;
  endtask

  task automatic send_random();
    int                        n, t, z, pick;
    logic [dbam_pkg::OP_W-1:0] op;
    n    = live_tracks();
    pick = $urandom_range(0, 99);
    if (n > 0 && $urandom_range(0, 9) < 8) begin
      t = $urandom_range(1, n);
      z = sectors_on_track(t);
      if (pick < 20) begin
        op = dbam_pkg::OP_QUERY;
      end else if (pick < 48) begin
        op = dbam_pkg::OP_ALLOC;
      end else if (pick < 72) begin
        op = dbam_pkg::OP_FREE;
      end else if (pick < 96) begin
        op = dbam_pkg::OP_NEXT;
      end else if (pick < 98) begin
        op = dbam_pkg::OP_FORMAT;
      end else begin
        op = dbam_pkg::OP_W'(OP_SPARE5 + $urandom_range(0, 2));
      end
      send_request(op, dbam_pkg::TRACK_W'(t), dbam_pkg::SECTOR_W'($urandom_range(0, z - 1)));
    end else begin
      send_request(dbam_pkg::OP_W'($urandom_range(0, (1 << dbam_pkg::OP_W) - 1)),
                   dbam_pkg::TRACK_W'($urandom_range(0, (1 << dbam_pkg::TRACK_W) - 1)),
                   dbam_pkg::SECTOR_W'($urandom_range(0, (1 << dbam_pkg::SECTOR_W) - 1)));
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_track_count(logic [dbam_pkg::TRACK_W-1:0] v);
    wait_for_results();
    repeat (SETTLE) @(posedge clk_i);
    track_count_we_i <= 1'b1;
    track_count_i    <= v;
    @(posedge clk_i);
    track_count_we_i <= 1'b0;
    tracks_cfg = v;
  endtask

  task automatic test_directed();
    send_request(dbam_pkg::OP_QUERY, ROOT_T, 0);
    send_request(dbam_pkg::OP_QUERY, 1, 0);
    send_request(dbam_pkg::OP_ALLOC, 1, 0);
    send_request(dbam_pkg::OP_ALLOC, 1, 0);
    send_request(dbam_pkg::OP_FREE, 1, 0);
    send_request(dbam_pkg::OP_FREE, 1, 0);
    send_request(dbam_pkg::OP_FREE, ROOT_T, 0);
    send_request(dbam_pkg::OP_QUERY, 0, 0);
    send_request(dbam_pkg::OP_ALLOC, 36, 0);
    send_request(dbam_pkg::OP_FREE, 63, 31);
    send_request(dbam_pkg::OP_QUERY, 17, 20);
    send_request(dbam_pkg::OP_QUERY, 17, 21);
    send_request(dbam_pkg::OP_ALLOC, 31, 16);
    send_request(dbam_pkg::OP_ALLOC, 35, 17);
    send_request(dbam_pkg::OP_QUERY, 24, 19);
    send_request(dbam_pkg::OP_NEXT, 63, 31);
    send_request(dbam_pkg::OP_NEXT, 0, 0);
    send_request(OP_SPARE5, 1, 0);
    send_request(OP_SPARE6, 40, 5);
    send_request(OP_SPARE7, 2, 31);
    send_request(dbam_pkg::OP_FORMAT, 5, 5);
    send_request(dbam_pkg::OP_QUERY, ROOT_T, 1);
  endtask

  // widen to 40 tracks without a format, then format
  task automatic test_unformatted_growth();
    set_track_count(40);
    send_request(dbam_pkg::OP_QUERY, 40, 0);
    send_request(dbam_pkg::OP_ALLOC, 38, 3);
    send_request(dbam_pkg::OP_FREE, 40, 16);
    send_request(dbam_pkg::OP_FREE, 40, 17);
    send_request(dbam_pkg::OP_QUERY, 40, 16);
    send_request(dbam_pkg::OP_NEXT, 0, 0);
    send_request(dbam_pkg::OP_FORMAT, 0, 0);
    send_request(dbam_pkg::OP_QUERY, 40, 16);
    send_request(dbam_pkg::OP_ALLOC, 40, 16);
    send_request(dbam_pkg::OP_NEXT, 0, 0);
  endtask

  // with nine tracks only track 9 is in reach of the search
  task automatic test_disk_full();
    set_track_count(9);
    send_request(dbam_pkg::OP_FORMAT, 0, 0);
    repeat (23) send_request(dbam_pkg::OP_NEXT, 0, 0);
    send_request(dbam_pkg::OP_FREE, 9, 5);
    send_request(dbam_pkg::OP_NEXT, 0, 0);
    send_request(dbam_pkg::OP_NEXT, 0, 0);
    send_request(dbam_pkg::OP_QUERY, ROOT_T, 0);
    send_request(dbam_pkg::OP_FREE, 1, 0);
    send_request(dbam_pkg::OP_NEXT, 9, 0);
  endtask

  task automatic test_track_count_limits();
    set_track_count(0);
    send_request(dbam_pkg::OP_QUERY, 1, 0);
    send_request(dbam_pkg::OP_NEXT, 0, 0);
    send_request(dbam_pkg::OP_FORMAT, 0, 0);
    send_request(dbam_pkg::OP_QUERY, 0, 0);
    send_request(dbam_pkg::OP_ALLOC, 1, 0);
    set_track_count(63);
    send_request(dbam_pkg::OP_FORMAT, 0, 0);
    send_request(dbam_pkg::OP_QUERY, 40, 16);
    send_request(dbam_pkg::OP_NEXT, 0, 0);
    send_request(dbam_pkg::OP_ALLOC, 40, 16);
  endtask

  task automatic test_random_mix(logic [dbam_pkg::TRACK_W-1:0] tracks, int count);
    set_track_count(tracks);
    send_request(dbam_pkg::OP_FORMAT, 0, 0);
    repeat (count) send_random();
  endtask

  // long receiver hold with the sender pushing, then a full drain
  task automatic test_backpressure();
    set_track_count(35);
    sender_gaps = 1'b0;
    hold_req <= ~hold_req;
    repeat (16) send_random();
    wait_for_results();
    sender_gaps = 1'b1;
    repeat (6) send_random();
  endtask

  task automatic test_steady_tail();
    sender_gaps = 1'b0;
    receiver_gaps <= 1'b0;
    repeat (50) send_random();
  endtask

  // receiver stall: random bursts, plus a long hold on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (gap_left != 0) begin
      gap_left    <= gap_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(1, 9);
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    dbam_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result returned with no request outstanding");
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        case (want.status)
          dbam_pkg::ST_INVALID: n_invalid++;
          dbam_pkg::ST_USED:    n_used++;
          dbam_pkg::ST_FULL:    n_full++;
          default:              ;
        endcase
        check_field("status", want.status, status_o);
        check_field("block_is_free", want.block_is_free, block_is_free_o);
        check_field("found_track", want.found_track, found_track_o);
        check_field("found_sector", want.found_sector, found_sector_o);
        check_field("track_free_count", want.track_free_count, track_free_count_o);
        check_field("disk_free_count", want.disk_free_count, disk_free_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STUCK_MAX) begin
      $display("watchdog: no request moved for %0d cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    tracks_cfg = dbam_pkg::RESET_TRACKS;
    format_map(live_tracks());
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_unformatted_growth();
    test_disk_full();
    test_track_count_limits();
    test_random_mix(35, 170);
    test_random_mix(40, 170);
    test_random_mix(37, 150);
    test_backpressure();
    test_steady_tail();
    wait_for_results();
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d requests over track counts 0, 9, 35, 37, 40 and 63, one %0d-cycle hold",
             n_sent, HOLD_LEN);
    $display("%0d results checked: %0d invalid, %0d already allocated, %0d disk full",
             n_checked, n_invalid, n_used, n_full);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dbam_pkg.sv
rtl/core/dbam_ram.sv
rtl/core/dbam_core.sv
rtl/core/disk_block_allocation_map_top.sv
tb/sv/disk_block_allocation_map_top_tb.sv
